/* rtl/core/kabf_pkg.sv */
// ----------------------------------------------------------------------------
// Kalman angle/bias filter package
// Shared widths, register indexes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package kabf_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned DtWidth   = 24;
   localparam int unsigned RegWidth  = 31;
   localparam int unsigned IdxWidth  = 2;

   localparam logic [RegWidth-1:0] AngleQReset = 31'd16777;
   localparam logic [RegWidth-1:0] BiasQReset  = 31'd50332;
   localparam logic [RegWidth-1:0] MeasRReset  = 31'd503316;

   localparam logic [IdxWidth-1:0] RegAngleQ = 2'd0;
   localparam logic [IdxWidth-1:0] RegBiasQ  = 2'd1;
   localparam logic [IdxWidth-1:0] RegMeasR  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RATE,
      ST_ANG,
      ST_T,
      ST_BRK,
      ST_P00,
      ST_P01,
      ST_P11,
      ST_INNOV,
      ST_DIV0,
      ST_DIV0_WAIT,
      ST_DIV1,
      ST_DIV1_WAIT,
      ST_CANG,
      ST_CBIAS,
      ST_C00,
      ST_C01,
      ST_C10,
      ST_C11,
      ST_OUT
   } state_type;

   // Division request and completion between sequencer and divider.
   typedef struct packed {
      logic                        start;
      logic signed [DataWidth-1:0] num;
      logic        [DataWidth:0]   den;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [DataWidth-1:0] quo;
   } div_rsp_type;

   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [65:0] x);
      logic signed [DataWidth-1:0] r;
      if (x > 66'sd2147483647) r = 32'sh7fffffff;
      else if (x < -66'sd2147483648) r = 32'sh80000000;
      else r = x[DataWidth-1:0];
      return r;
   endfunction

endpackage

/* rtl/core/kabf_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel interfaces
// Request, response and CSR write channels of the filter.
// ----------------------------------------------------------------------------
interface kabf_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] time_step;
   logic signed [31:0] measured_angle;
   logic signed [31:0] measured_rate;
   modport source (output valid, time_step, measured_angle, measured_rate, input ready);
   modport sink   (input valid, time_step, measured_angle, measured_rate, output ready);
endinterface

interface kabf_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] filtered_angle;
   logic signed [31:0] bias_estimate;
   modport source (output valid, filtered_angle, bias_estimate, input ready);
   modport sink   (input valid, filtered_angle, bias_estimate, output ready);
endinterface

interface kabf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/kalman_angle_bias_filter.sv */
// ----------------------------------------------------------------------------
// Kalman angle/bias filter
// Two-state fixed-point Kalman filter on a shared multiplier and divider.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                   Handshake
//  req      in   time_step, measured_angle, measured_rate  valid/ready
//  rsp      out  filtered_angle, bias_estimate             valid/ready
//  csr      in   index, data (31 bits used)                valid/ready
//
// The response becomes valid once the sequencer has been launched, has run 15
// steps around one 33x33 multiplier, and has completed two gain divisions
// (issue plus 56 restoring steps, then the quotient is handed over). With a
// non-positive innovation variance both divisions are skipped.
// Reset is synchronous; it clears the state and covariance and loads the noise registers with their defaults.
// A request is accepted only when the core and the response register are
// empty, so a stalled response holds the block without losing data.
// CSR writes are always accepted; indexes beyond the three registers are dropped.
module kalman_angle_bias_filter (
   input logic    clock,
   input logic    reset,
   kabf_req_if.sink   req,
   kabf_rsp_if.source rsp,
   kabf_csr_if.sink   csr
);
   import kabf_pkg::*;

   logic [RegWidth-1:0] qa_ff, qb_ff, rm_ff;
   logic busy, done;
   logic signed [31:0] ang, bias;
   div_req_type dreq;
   div_rsp_type drsp;
   logic [23:0] dt_ff;
   logic signed [31:0] meas_ff, rate_ff;
   logic rsp_valid_ff;
   logic signed [31:0] ang_out_ff, bias_out_ff;
   logic start_ff;
   logic accept;

   assign accept    = req.valid && req.ready;
   assign req.ready = !busy && !start_ff && !rsp_valid_ff;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= AngleQReset;
         qb_ff <= BiasQReset;
         rm_ff <= MeasRReset;
      end else if (csr.valid) begin
         if (csr.index == RegAngleQ) qa_ff <= csr.data[RegWidth-1:0];
         else if (csr.index == RegBiasQ) qb_ff <= csr.data[RegWidth-1:0];
         else if (csr.index == RegMeasR) rm_ff <= csr.data[RegWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= accept;
         if (done) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         dt_ff   <= req.time_step;
         meas_ff <= req.measured_angle;
         rate_ff <= req.measured_rate;
      end
      if (done) begin
         ang_out_ff  <= ang;
         bias_out_ff <= bias;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.filtered_angle = ang_out_ff;
   assign rsp.bias_estimate  = bias_out_ff;

   kabf_core u_core (
      .clock(clock), .reset(reset), .start(start_ff),
      .dt(dt_ff), .meas(meas_ff), .rate_in(rate_ff),
      .q_angle(qa_ff), .q_bias(qb_ff), .r_meas(rm_ff),
      .busy(busy), .done(done), .ang_out(ang), .bias_out(bias),
      .div_req(dreq), .div_rsp(drsp)
   );

   kabf_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assert property (@(posedge clock) disable iff (reset) accept |=> start_ff)
      else $error("accepted request did not start the core");
   assert property (@(posedge clock) disable iff (reset) done |-> !rsp_valid_ff)
      else $error("response overwritten");
   assert property (@(posedge clock) disable iff (reset) busy |-> !req.ready)
      else $error("ready while busy");
endmodule

/* rtl/core/kabf_div.sv */
// ----------------------------------------------------------------------------
// Gain divider
// Restoring divider, one quotient bit per cycle: (num << 24) / den, truncated
// toward zero and saturated to signed 32 bits. den is positive.
// ----------------------------------------------------------------------------
module kabf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  kabf_pkg::div_req_type req,
   output kabf_pkg::div_rsp_type rsp
);
   import kabf_pkg::*;

   localparam int unsigned NumBits = 56;   // |num| << 24 fits in 56 bits
   localparam int unsigned CntW    = 6;

   logic [NumBits-1:0] rem_num_ff, rem_num_in;
   logic [DataWidth+1:0] rem_ff, rem_in;
   logic [NumBits-1:0] quo_ff, quo_in;
   logic [DataWidth:0] den_ff, den_in;
   logic               neg_ff, neg_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DataWidth+1:0] trial;
   logic [DataWidth:0]   mag;
   logic signed [65:0]   sq;

   always_comb begin
      rem_num_in = rem_num_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      mag        = req.num[DataWidth-1] ? (DataWidth+1)'(-{req.num[DataWidth-1], req.num})
                                        : {1'b0, req.num};
      trial      = {rem_ff[DataWidth:0], rem_num_ff[NumBits-1]};
      if (req.start) begin
         // The magnitude is at most 2^31, so its low 32 bits hold it.
         rem_num_in = {mag[DataWidth-1:0], 24'd0};
         rem_in     = '0;
         quo_in     = '0;
         den_in     = req.den;
         neg_in     = req.num[DataWidth-1];
         cnt_in     = CntW'(NumBits - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_num_in = {rem_num_ff[NumBits-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumBits-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_num_ff <= rem_num_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
   end

   always_comb begin
      sq = neg_ff ? -$signed({10'd0, quo_ff}) : $signed({10'd0, quo_ff});
      rsp.done = done_ff;
      rsp.quo  = sat32(sq);
   end

   assert property (@(posedge clock) disable iff (reset) req.start |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("divider done without work");
endmodule

/* rtl/core/kabf_core.sv */
// ----------------------------------------------------------------------------
// Filter sequencer and shared multiply-accumulate datapath
// One 33x33 multiplier, registered, then round, add and saturate per step.
// ----------------------------------------------------------------------------
module kabf_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic        [23:0]             dt,
   input  logic signed [31:0]             meas,
   input  logic signed [31:0]             rate_in,
   input  logic        [30:0]             q_angle,
   input  logic        [30:0]             q_bias,
   input  logic        [30:0]             r_meas,
   output logic                           busy,
   output logic                           done,
   output logic signed [31:0]             ang_out,
   output logic signed [31:0]             bias_out,
   output kabf_pkg::div_req_type          div_req,
   input  kabf_pkg::div_rsp_type          div_rsp
);
   import kabf_pkg::*;

   state_type state_ff, state_in;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] rate_ff, rate_in_n, t_ff, t_in, brk_ff, brk_in, inn_ff, inn_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [31:0] o00_ff, o01_ff;
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod_ff;
   logic signed [65:0] rnd16, rnd24;
   logic signed [32:0] s_val;
   logic               s_pos_ff, s_pos_in;

   // Multiplier operands are chosen in the step before the one that uses the product:
   // the product is registered one state ahead of its consumer.
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         ST_RATE:  begin ma = {9'd0, dt}; mb = 33'(rate_in_n); end
         ST_ANG:   begin ma = {9'd0, dt}; mb = 33'(p11_ff); end
         ST_P00:   begin ma = {9'd0, dt}; mb = 33'(brk_ff); end
         ST_P01:   begin ma = {9'd0, dt}; mb = {2'b0, q_bias}; end
         ST_DIV1_WAIT: begin ma = 33'(k0_in); mb = 33'(inn_ff); end
         ST_CANG:  begin ma = 33'(k1_ff); mb = 33'(inn_ff); end
         ST_CBIAS: begin ma = 33'(k0_ff); mb = 33'(p00_ff); end
         ST_C00:   begin ma = 33'(k0_ff); mb = 33'(p01_ff); end
         ST_C01:   begin ma = 33'(k1_ff); mb = 33'(o00_ff); end
         ST_C10:   begin ma = 33'(k1_ff); mb = 33'(o01_ff); end
         default:  begin ma = '0; mb = '0; end
      endcase
   end

   always_comb begin
      rnd16 = (prod_ff + 66'sd32768) >>> 16;
      rnd24 = (prod_ff + 66'sd8388608) >>> 24;
      s_val = 33'(p00_ff) + $signed({2'b0, r_meas});
   end

   always_comb begin
      state_in  = state_ff;
      ang_in = ang_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      rate_in_n = rate_ff; t_in = t_ff; brk_in = brk_ff; inn_in = inn_ff;
      k0_in = k0_ff; k1_in = k1_ff; s_pos_in = s_pos_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_RATE;
         ST_RATE: begin
            rate_in_n = sat32(66'(rate_in) - 66'(bias_ff));
            state_in = ST_ANG;
         end
         ST_ANG: begin
            ang_in = sat32(66'(ang_ff) + rnd16);
            state_in = ST_T;
         end
         ST_T: begin
            t_in = sat32(rnd16);
            state_in = ST_BRK;
         end
         ST_BRK: begin
            brk_in = sat32(66'(t_ff) - 66'(p01_ff) - 66'(p10_ff) + 66'($signed({1'b0, q_angle})));
            state_in = ST_P00;
         end
         ST_P00: begin
            p01_in = sat32(66'(p01_ff) - 66'(t_ff));
            p10_in = sat32(66'(p10_ff) - 66'(t_ff));
            state_in = ST_P01;
         end
         ST_P01: begin
            p00_in = sat32(66'(p00_ff) + rnd16);
            state_in = ST_P11;
         end
         ST_P11: begin
            p11_in = sat32(66'(p11_ff) + rnd16);
            state_in = ST_INNOV;
         end
         ST_INNOV: begin
            inn_in = sat32(66'(meas) - 66'(ang_ff));
            s_pos_in = (s_val > 0);
            k0_in = '0; k1_in = '0;
            state_in = (s_val > 0) ? ST_DIV0 : ST_DIV1_WAIT;
         end
         ST_DIV0: state_in = ST_DIV0_WAIT;
         ST_DIV0_WAIT: if (div_rsp.done) begin
            k0_in = div_rsp.quo;
            state_in = ST_DIV1;
         end
         ST_DIV1: state_in = ST_DIV1_WAIT;
         ST_DIV1_WAIT: if (!s_pos_ff || div_rsp.done) begin
            if (s_pos_ff) k1_in = div_rsp.quo;
            k0_in = k0_ff;
            state_in = ST_CANG;
         end
         ST_CANG: begin
            ang_in = sat32(66'(ang_ff) + rnd24);
            state_in = ST_CBIAS;
         end
         ST_CBIAS: begin
            bias_in = sat32(66'(bias_ff) + rnd24);
            state_in = ST_C00;
         end
         ST_C00: begin
            p00_in = sat32(66'(p00_ff) - rnd24);
            state_in = ST_C01;
         end
         ST_C01: begin
            p01_in = sat32(66'(p01_ff) - rnd24);
            state_in = ST_C10;
         end
         ST_C10: begin
            p10_in = sat32(66'(p10_ff) - rnd24);
            state_in = ST_C11;
         end
         ST_C11: begin
            p11_in = sat32(66'(p11_ff) - rnd24);
            state_in = ST_OUT;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // The covariance correction uses P00 and P01 as they were before it
   // started. Both are captured in C00, before either one changes.
   always_ff @(posedge clock) begin
      if (state_ff == ST_C00) begin
         o00_ff <= p00_ff;
         o01_ff <= p01_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
      end else begin
         state_ff <= state_in;
         ang_ff <= ang_in; bias_ff <= bias_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
      end
      rate_ff  <= rate_in_n;
      t_ff     <= t_in;
      brk_ff   <= brk_in;
      inn_ff   <= inn_in;
      k0_ff    <= k0_in;
      k1_ff    <= k1_in;
      s_pos_ff <= s_pos_in;
      prod_ff  <= 66'(ma) * 66'(mb);
   end

   always_comb begin
      busy     = (state_ff != ST_IDLE);
      done     = (state_ff == ST_OUT);
      ang_out  = ang_ff;
      bias_out = bias_ff;
      div_req.start = (state_ff == ST_DIV0) || (state_ff == ST_DIV1);
      div_req.num   = (state_ff == ST_DIV0) ? p00_ff : p10_ff;
      div_req.den   = s_val[32:0];
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> state_ff == ST_RATE)
      else $error("sequencer did not start");
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> s_pos_ff)
      else $error("divide issued with non-positive variance");
   assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle");
endmodule

/* test/kalman_angle_bias_filter_tb.sv */
// ----------------------------------------------------------------------------
// Kalman angle/bias filter testbench
// Drives requests through the filter, predicts the angle and bias that each
// request yields with a fixed-point model of its own, and compares every
// response field by field. The noise registers are changed between phases.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_tb;
   import kabf_pkg::*;

   typedef struct packed {
      logic [23:0]        time_step;
      logic signed [31:0] measured_angle;
      logic signed [31:0] measured_rate;
   } imu_sample_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] bias_estimate;
   } estimate_type;

   localparam longint CycleLimit = 2000000;
   // An index past the three noise registers; writes to it are dropped.
   localparam logic [IdxWidth-1:0] RegUnused = 2'd3;

   logic clock;
   logic reset;

   kabf_req_if req_ch ();
   kabf_rsp_if rsp_ch ();
   kabf_csr_if csr_ch ();

   kalman_angle_bias_filter u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   // Filter state held by the predictor.
   logic [30:0]        q_angle, q_bias, meas_r;
   logic signed [31:0] est_angle, est_bias;
   logic signed [31:0] cov [4];

   imu_sample_type pending_samples [$];
   estimate_type   expected_estimates [$];
   int          mismatch_count;
   int          sent_count;
   int          checked_count;
   longint      cycle_count;

   // ------------------------------------------------------------------
   // Clock and cycle limit.
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Fixed-point helpers. All intermediate math is done in 128 bits so
   // that no product can overflow before saturation.
   // ------------------------------------------------------------------
   function automatic logic signed [127:0] clamp32(input logic signed [127:0] x);
      logic signed [127:0] r;
      if (x > 128'sd2147483647) r = 128'sd2147483647;
      else if (x < -128'sd2147483648) r = -128'sd2147483648;
      else r = x;
      return r;
   endfunction

   // Round half up, then drop s fraction bits (arithmetic shift is a floor).
   function automatic logic signed [127:0] round_drop(input logic signed [127:0] x,
                                                      input int s);
      logic signed [127:0] one;
      one = 128'sd1;
      return (x + (one <<< (s - 1))) >>> s;
   endfunction

   // Gain quotient in Q8.24, truncated toward zero then clamped.
   function automatic logic signed [127:0] gain_q24(input logic signed [127:0] num,
                                                     input logic signed [127:0] den);
      logic signed [127:0] n;
      n = num * 128'sd16777216;
      return clamp32(n / den);
   endfunction

   // Advances the predictor by one sample and returns the expected estimate.
   function automatic estimate_type filter_step(input imu_sample_type smp);
      logic signed [127:0] dt, rate, ang, bias, t, brk, innov, s, k0, k1;
      logic signed [127:0] p00, p01, p10, p11, o00, o01;
      estimate_type e;
      dt   = $signed({104'd0, smp.time_step});
      ang  = est_angle;
      bias = est_bias;
      p00  = cov[0];
      p01  = cov[1];
      p10  = cov[2];
      p11  = cov[3];
      rate = clamp32(128'(smp.measured_rate) - bias);
      ang  = clamp32(ang + round_drop(dt * rate, 16));
      t    = clamp32(round_drop(dt * p11, 16));
      brk  = clamp32(t - p01 - p10 + $signed({97'd0, q_angle}));
      p00  = clamp32(p00 + round_drop(dt * brk, 16));
      p01  = clamp32(p01 - t);
      p10  = clamp32(p10 - t);
      p11  = clamp32(p11 + round_drop($signed({97'd0, q_bias}) * dt, 16));
      innov = clamp32(128'(smp.measured_angle) - ang);
      s    = p00 + $signed({97'd0, meas_r});
      k0   = 0;
      k1   = 0;
      if (s > 0) begin
         k0 = gain_q24(p00, s);
         k1 = gain_q24(p10, s);
      end
      ang  = clamp32(ang + round_drop(k0 * innov, 24));
      bias = clamp32(bias + round_drop(k1 * innov, 24));
      o00  = p00;
      o01  = p01;
      p00  = clamp32(p00 - round_drop(k0 * o00, 24));
      p01  = clamp32(p01 - round_drop(k0 * o01, 24));
      p10  = clamp32(p10 - round_drop(k1 * o00, 24));
      p11  = clamp32(p11 - round_drop(k1 * o01, 24));
      est_angle = ang[31:0];
      est_bias  = bias[31:0];
      cov[0] = p00[31:0];
      cov[1] = p01[31:0];
      cov[2] = p10[31:0];
      cov[3] = p11[31:0];
      e.filtered_angle = ang[31:0];
      e.bias_estimate  = bias[31:0];
      return e;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("Mismatch on response %0d: %s got %h expected %h",
               checked_count, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Request driver: changes its outputs on the falling edge. A request
   // counts as accepted at the rising edge where valid and ready are high,
   // so the driver looks back at the values sampled at that edge.
   // ------------------------------------------------------------------
   logic req_fire_seen;
   int   req_gap;
   logic driver_hold;

   always @(posedge clock) req_fire_seen <= req_ch.valid && req_ch.ready;

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap <= $urandom_range(0, 5);
      end else begin
         if (req_fire_seen) begin
            expected_estimates.push_back(filter_step(pending_samples.pop_front()));
            sent_count++;
         end
         if (req_ch.valid && !req_fire_seen) begin
            // Request still waiting for ready: hold it.
         end else if (driver_hold || pending_samples.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (req_ch.valid && req_fire_seen && req_gap == 0) begin
            // Back-to-back: keep valid high and present the next request.
            {req_ch.time_step, req_ch.measured_angle, req_ch.measured_rate}
               <= pending_samples[0];
            req_gap <= $urandom_range(0, 5);
         end else if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else begin
            req_ch.valid <= 1'b1;
            {req_ch.time_step, req_ch.measured_angle, req_ch.measured_rate}
               <= pending_samples[0];
            req_gap <= $urandom_range(0, 5);
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: samples at the rising edge and draws a random
   // stall ahead of each response.
   // ------------------------------------------------------------------
   int   rsp_stall;
   logic rsp_fire_seen;

   always @(posedge clock) rsp_fire_seen <= rsp_ch.valid && rsp_ch.ready;

   always @(posedge clock) begin
      estimate_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_estimates.size() == 0) begin
            $display("Unexpected response: angle %h bias %h",
                     rsp_ch.filtered_angle, rsp_ch.bias_estimate);
            mismatch_count++;
         end else begin
            want = expected_estimates.pop_front();
            if (rsp_ch.filtered_angle !== want.filtered_angle)
               report_mismatch("filtered_angle", rsp_ch.filtered_angle, want.filtered_angle);
            if (rsp_ch.bias_estimate !== want.bias_estimate)
               report_mismatch("bias_estimate", rsp_ch.bias_estimate, want.bias_estimate);
         end
         checked_count++;
      end
   end

   // The stall counts down only while a response is waiting, so ready stays low
   // for a waiting response until the stall drawn for it has run out.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 5);
      end else if (rsp_fire_seen) begin
         // Response just taken: draw the stall for the next one.
         rsp_stall <= $urandom_range(0, 5);
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         if (rsp_ch.valid) rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_estimates.size() != 0
             || req_ch.valid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Writes one noise register and mirrors it in the predictor. CSR writes
   // happen only while the filter is idle.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         RegAngleQ: q_angle = value[30:0];
         RegBiasQ:  q_bias  = value[30:0];
         RegMeasR:  meas_r  = value[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic add_sample(input logic [23:0] dt, input logic [31:0] ang,
                             input logic [31:0] rate);
      imu_sample_type s;
      s.time_step      = dt;
      s.measured_angle = ang;
      s.measured_rate  = rate;
      pending_samples.push_back(s);
   endtask

   // Mostly realistic IMU traffic: small time steps and moderate angles,
   // with occasional full-range values to exercise saturation.
   task automatic add_random_samples(input int count);
      logic [23:0] dt;
      logic [31:0] ang, rate;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: dt = 24'($urandom());
            1: dt = 24'd0;
            default: dt = 24'($urandom_range(0, 24'h004000));
         endcase
         if ($urandom_range(0, 7) == 0) ang = $urandom();
         else ang = $signed($urandom_range(0, 32'h00B40000)) - 32'sh005A0000;
         if ($urandom_range(0, 7) == 0) rate = $urandom();
         else rate = $signed($urandom_range(0, 32'h01F40000)) - 32'sh00FA0000;
         add_sample(dt, ang, rate);
      end
   endtask

   task automatic random_regs();
      write_reg(RegAngleQ, $urandom_range(0, 32'h00100000));
      write_reg(RegBiasQ,  $urandom_range(0, 32'h00100000));
      write_reg(RegMeasR,  $urandom());
   endtask

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      cycle_count = 0;
      mismatch_count = 0;
      sent_count = 0;
      checked_count = 0;
      req_ch.valid = 1'b0;
      req_ch.time_step = '0;
      req_ch.measured_angle = '0;
      req_ch.measured_rate = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      driver_hold = 1'b0;
      q_angle = AngleQReset;
      q_bias  = BiasQReset;
      meas_r  = MeasRReset;
      est_angle = '0;
      est_bias = '0;
      for (int i = 0; i < 4; i++) cov[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Non-positive innovation variance: zero measurement and angle noise
      // with the covariance still zero from reset and a zero time step
      // gives S equal to zero.
      write_reg(RegMeasR, 32'd0);
      write_reg(RegAngleQ, 32'd0);
      add_sample(24'd0, 32'sh00050000, 32'sh00010000);
      add_sample(24'd0, 32'shFFFB0000, 32'sh0);
      wait_drained();
      write_reg(RegAngleQ, AngleQReset);
      write_reg(RegMeasR, MeasRReset);

      // Directed requests with reset register values: zero time step,
      // field extremes, and large steps that drive the state into saturation.
      add_sample(24'd0, 32'sh00010000, 32'sh0);
      add_sample(24'h000290, 32'sh000A0000, 32'sh00020000);
      add_sample(24'hFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      add_sample(24'hFFFFFF, 32'sh80000000, 32'sh80000000);
      add_sample(24'h000001, 32'sh80000000, 32'sh7FFFFFFF);
      add_sample(24'h800000, 32'sh7FFFFFFF, 32'sh80000000);
      add_sample(24'h000147, 32'hFFFFFFFF, 32'hFFFFFFFF);
      add_sample(24'd0, 32'sh0, 32'sh0);
      wait_drained();

      // Register extremes, plus a write to an unused index that must be dropped.
      write_reg(RegAngleQ, 32'h7FFFFFFF);
      write_reg(RegBiasQ, 32'hFFFFFFFF);
      write_reg(RegMeasR, 32'h7FFFFFFF);
      write_reg(RegUnused, 32'h12345678);
      add_sample(24'h000400, 32'sh00100000, 32'shFFF00000);
      add_sample(24'hFFFFFF, 32'shFFF00000, 32'sh00100000);
      add_sample(24'h000200, 32'sh0, 32'sh0);
      wait_drained();

      // Random phases with changing registers. The sender waits for every
      // response at each phase boundary.
      write_reg(RegAngleQ, AngleQReset);
      write_reg(RegBiasQ, BiasQReset);
      write_reg(RegMeasR, MeasRReset);
      add_random_samples(600);
      wait_drained();
      for (int ph = 0; ph < 5; ph++) begin
         random_regs();
         add_random_samples(230);
         wait_drained();
      end

      $display("Sent %0d requests and checked %0d responses across several",
               sent_count, checked_count);
      $display("noise register settings, with zero and full-range time steps.");
      if (mismatch_count == 0 && expected_estimates.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("Mismatches: %0d, responses still expected: %0d",
                  mismatch_count, expected_estimates.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/kabf_pkg.sv
rtl/core/kabf_if.sv
rtl/core/kabf_div.sv
rtl/core/kabf_core.sv
rtl/core/kalman_angle_bias_filter.sv
test/kalman_angle_bias_filter_tb.sv
